### rtl/frd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_pkg: shared definitions for the fraction reducer
// Default value width and the codes carried in the result tuser.
// ----------------------------------------------------------------------------
package frd_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_DEN  = 2'd1,
		ST_NEG_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		KIND_INT  = 1'b0,
		KIND_FRAC = 1'b1
	} kind_t;

endpackage

### rtl/fraction_reduce_int16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reduce_int16: reduce a signed fraction to lowest terms
// Moves the sign to the numerator, divides both values by their greatest
// common divisor and reports integer or fraction, with an error status.
// ----------------------------------------------------------------------------
// One request enters per cycle and passes through one decode stage,
// 2*VALUE_WIDTH stages of binary GCD steps, one stage to form the divisor,
// VALUE_WIDTH stages of restoring division (both values in parallel lanes)
// and one output register. The whole pipeline advances when the output
// register is empty or taken, so a stall on the output holds every stage
// and s_axis_tready drops with it.
module fraction_reduce_int16 #(
	parameter int unsigned VALUE_WIDTH = frd_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// numerator_in, denominator_in, zero fill
	input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// numerator_out, denominator_out, zero fill
	output logic [((2*VALUE_WIDTH-1+7)/8)*8-1:0] m_axis_tdata,
	// result_kind, status
	output logic [2:0] m_axis_tuser
);
	import frd_pkg::*;

	localparam int unsigned L   = VALUE_WIDTH;
	localparam int unsigned NG  = 2 * VALUE_WIDTH;
	localparam int unsigned KW  = $clog2(VALUE_WIDTH) + 1;
	localparam int unsigned OTW = ((2*VALUE_WIDTH-1+7)/8)*8;

	logic adv;

	// one binary GCD step on (a, b) with common power of two k
	function automatic logic [2*L+KW-1:0] gcd_step(input logic [L-1:0] a,
			input logic [L-1:0] b, input logic [KW-1:0] k);
		logic [L-1:0]  na;
		logic [L-1:0]  nb;
		logic [KW-1:0] nk;
		na = a;
		nb = b;
		nk = k;
		if (a != '0 && b != '0) begin
			priority if (!a[0] && !b[0]) begin
				na = a >> 1;
				nb = b >> 1;
				nk = k + KW'(1);
			end else if (!a[0]) begin
				na = a >> 1;
			end else if (!b[0]) begin
				nb = b >> 1;
			end else if (a >= b) begin
				na = (a - b) >> 1;
			end else begin
				nb = (b - a) >> 1;
			end
		end
		return {na, nb, nk};
	endfunction

	// one restoring division step: shift in a dividend bit, subtract if it fits
	function automatic logic [2*L-1:0] div_step(input logic [L-1:0] r,
			input logic [L-1:0] q, input logic [L-1:0] g);
		logic [L:0]   cand;
		logic [L-1:0] nr;
		logic         qb;
		cand = {r, q[L-1]};
		if (cand >= {1'b0, g}) begin
			cand = cand - {1'b0, g};
			qb   = 1'b1;
		end else begin
			qb   = 1'b0;
		end
		nr = cand[L-1:0];
		return {nr, q[L-2:0], qb};
	endfunction

	// advance everything when the output register is free
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// ---------------- decode stage ----------------
	logic signed [L-1:0] num_in;
	logic signed [L-1:0] den_in;
	logic [L-1:0]        num_mag;
	logic [L-1:0]        den_mag;
	logic [L-1:0]        min_val;
	status_t             dec_st;

	assign num_in  = s_axis_tdata[L-1:0];
	assign den_in  = s_axis_tdata[2*L-1:L];
	assign min_val = {1'b1, {(L-1){1'b0}}};
	assign num_mag = num_in[L-1] ? (~num_in + L'(1)) : num_in;
	assign den_mag = den_in[L-1] ? (~den_in + L'(1)) : den_in;

	// classify the request
	always_comb begin
		priority if (den_in == '0) begin
			dec_st = ST_ZERO_DEN;
		end else if (den_in[L-1] && (num_in == min_val || den_in == min_val)) begin
			dec_st = ST_NEG_RANGE;
		end else begin
			dec_st = ST_OK;
		end
	end

	// GCD stage arrays; index 0 is the decode register
	logic          gv_s  [NG+1];
	logic [L-1:0]  ga_s  [NG+1];
	logic [L-1:0]  gb_s  [NG+1];
	logic [KW-1:0] gk_s  [NG+1];
	logic [L-1:0]  gm_s  [NG+1];
	logic [L-1:0]  gd_s  [NG+1];
	logic          gn_s  [NG+1];
	status_t       gst_s [NG+1];

	// load the decode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_s[0] <= 1'b0;
		end else if (adv) begin
			gv_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gst_s[0] <= dec_st;
			gk_s[0]  <= '0;
			gn_s[0]  <= num_in[L-1] ^ den_in[L-1];
			if (dec_st == ST_OK) begin
				ga_s[0] <= num_mag;
				gb_s[0] <= den_mag;
				gm_s[0] <= num_mag;
				gd_s[0] <= den_mag;
			end else begin
				ga_s[0] <= '0;
				gb_s[0] <= L'(1);
				gm_s[0] <= '0;
				gd_s[0] <= L'(1);
			end
		end
	end

	// ---------------- GCD step stages ----------------
	for (genvar i = 1; i <= NG; i++) begin : g_gcd
		logic [2*L+KW-1:0] nxt;
		assign nxt = gcd_step(ga_s[i-1], gb_s[i-1], gk_s[i-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				gv_s[i] <= 1'b0;
			end else if (adv) begin
				gv_s[i] <= gv_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				{ga_s[i], gb_s[i], gk_s[i]} <= nxt;
				gm_s[i]  <= gm_s[i-1];
				gd_s[i]  <= gd_s[i-1];
				gn_s[i]  <= gn_s[i-1];
				gst_s[i] <= gst_s[i-1];
			end
		end
	end

	// ---------------- divisor stage, then division lanes ----------------
	logic          dv_s  [L+1];
	logic [L-1:0]  dg_s  [L+1];
	logic [L-1:0]  rn_s  [L+1];
	logic [L-1:0]  qn_s  [L+1];
	logic [L-1:0]  rd_s  [L+1];
	logic [L-1:0]  qd_s  [L+1];
	logic          dn_s  [L+1];
	status_t       dst_s [L+1];
	logic [L-1:0]  gcd_val;

	// one of a, b is zero now; restore the common power of two
	assign gcd_val = (ga_s[NG] | gb_s[NG]) << gk_s[NG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (adv) begin
			dv_s[0] <= gv_s[NG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dg_s[0]  <= (gcd_val == '0) ? L'(1) : gcd_val;
			rn_s[0]  <= '0;
			qn_s[0]  <= gm_s[NG];
			rd_s[0]  <= '0;
			qd_s[0]  <= gd_s[NG];
			dn_s[0]  <= gn_s[NG];
			dst_s[0] <= gst_s[NG];
		end
	end

	for (genvar j = 1; j <= L; j++) begin : g_div
		logic [2*L-1:0] nn;
		logic [2*L-1:0] nd;
		assign nn = div_step(rn_s[j-1], qn_s[j-1], dg_s[j-1]);
		assign nd = div_step(rd_s[j-1], qd_s[j-1], dg_s[j-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j] <= 1'b0;
			end else if (adv) begin
				dv_s[j] <= dv_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				{rn_s[j], qn_s[j]} <= nn;
				{rd_s[j], qd_s[j]} <= nd;
				dg_s[j]  <= dg_s[j-1];
				dn_s[j]  <= dn_s[j-1];
				dst_s[j] <= dst_s[j-1];
			end
		end
	end

	// ---------------- output register ----------------
	logic            out_v_q;
	logic [L-1:0]    num_out_q;
	logic [L-2:0]    den_out_q;
	kind_t           kind_q;
	status_t         st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_s[L];
		end
	end

	// apply the sign and pick the kind
	always_ff @(posedge clk) begin
		if (adv) begin
			st_q <= dst_s[L];
			if (dst_s[L] == ST_OK) begin
				num_out_q <= dn_s[L] ? (~qn_s[L] + L'(1)) : qn_s[L];
				den_out_q <= qd_s[L][L-2:0];
				kind_q    <= (qd_s[L] == L'(1)) ? KIND_INT : KIND_FRAC;
			end else begin
				num_out_q <= '0;
				den_out_q <= (L-1)'(1);
				kind_q    <= KIND_INT;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OTW'({den_out_q, num_out_q});
	assign m_axis_tuser  = {st_q, kind_q};

endmodule

### rtl/frd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frd_checker: port-level checks for the fraction reducer
// Watches the stream ports and the fields of each result.
// ----------------------------------------------------------------------------
module frd_checker #(
	parameter int unsigned VALUE_WIDTH = frd_pkg::VALUE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((2*VALUE_WIDTH-1+7)/8)*8-1:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser
);
	import frd_pkg::*;

	localparam int unsigned L = VALUE_WIDTH;

	logic [L-1:0] num_f;
	logic [L-2:0] den_f;
	logic [1:0]   st_f;
	logic         kind_f;

	assign num_f  = m_axis_tdata[L-1:0];
	assign den_f  = m_axis_tdata[2*L-2:L];
	assign kind_f = m_axis_tuser[0];
	assign st_f   = m_axis_tuser[2:1];

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// block new requests while the output is stalled
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken during output stall");

	// error results are 0/1 integers
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st_f != ST_OK |-> num_f == '0 && den_f == (L-1)'(1)
		&& kind_f == KIND_INT && (st_f == ST_ZERO_DEN || st_f == ST_NEG_RANGE))
		else $error("bad error result");

	// kind agrees with the denominator
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st_f == ST_OK |-> den_f != '0
		&& ((kind_f == KIND_INT) == (den_f == (L-1)'(1))))
		else $error("kind does not match denominator");

endmodule

bind fraction_reduce_int16 frd_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_frd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
